// File: hw/rtl/piano_key_spectrum_meter_assert.svh
// Assertion macros for the key spectrum meter
`ifndef PIANO_KEY_SPECTRUM_METER_ASSERT_SVH
`define PIANO_KEY_SPECTRUM_METER_ASSERT_SVH
// property that holds every clock outside reset
`define PKSM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pksm check failed");
// same, but also checked during reset
`define PKSM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("pksm check failed");
`endif

// File: hw/rtl/pksm_pkg.sv
// ----------------------------------------------------------------------------
// pksm_pkg
// Shared types, constants and the key pitch table of the spectrum meter.
// ----------------------------------------------------------------------------
package pksm_pkg;
    localparam int MAX_FFT_LOG2 = 12;
    localparam int NUM_KEYS     = 52;
    localparam int STORE_DEPTH  = (1 << (MAX_FFT_LOG2 - 1)) + 2;
    localparam int BIN_W        = 12;
    localparam int SECTOR_Q8    = 15360;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic [0:0] REG_SAMPLE_RATE = 1'b0;
    localparam logic [0:0] REG_FFT_LOG2    = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [11:0] bin;
        logic [23:0] re;
        logic [23:0] im;
        logic [5:0]  key;
    } t_item;

    typedef struct packed {
        logic [5:0] key;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       lit;
    } t_result;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV, ST_READ, ST_WAIT, ST_MAG, ST_SQRT, ST_PEAK,
        ST_HUE, ST_SECT, ST_COLOR, ST_DECAY, ST_OUT
    } t_state;

    function automatic logic [20:0] key_freq(input logic [5:0] k);
        logic [20:0] f;
        case (k)
            6'd0: f = 21'd7040;     6'd1: f = 21'd7902;     6'd2: f = 21'd8372;
            6'd3: f = 21'd9397;     6'd4: f = 21'd10548;    6'd5: f = 21'd11175;
            6'd6: f = 21'd12544;    6'd7: f = 21'd14080;    6'd8: f = 21'd15804;
            6'd9: f = 21'd16744;    6'd10: f = 21'd18795;   6'd11: f = 21'd21096;
            6'd12: f = 21'd22351;   6'd13: f = 21'd25088;   6'd14: f = 21'd28160;
            6'd15: f = 21'd31609;   6'd16: f = 21'd33488;   6'd17: f = 21'd37589;
            6'd18: f = 21'd42192;   6'd19: f = 21'd44701;   6'd20: f = 21'd50175;
            6'd21: f = 21'd56320;   6'd22: f = 21'd63217;   6'd23: f = 21'd66976;
            6'd24: f = 21'd75178;   6'd25: f = 21'd84385;   6'd26: f = 21'd89402;
            6'd27: f = 21'd100351;  6'd28: f = 21'd112640;  6'd29: f = 21'd126434;
            6'd30: f = 21'd133952;  6'd31: f = 21'd150356;  6'd32: f = 21'd168769;
            6'd33: f = 21'd178805;  6'd34: f = 21'd200702;  6'd35: f = 21'd225280;
            6'd36: f = 21'd252868;  6'd37: f = 21'd267904;  6'd38: f = 21'd300713;
            6'd39: f = 21'd337539;  6'd40: f = 21'd357609;  6'd41: f = 21'd401403;
            6'd42: f = 21'd450560;  6'd43: f = 21'd505736;  6'd44: f = 21'd535808;
            6'd45: f = 21'd601426;  6'd46: f = 21'd675077;  6'd47: f = 21'd715220;
            6'd48: f = 21'd802806;  6'd49: f = 21'd901120;  6'd50: f = 21'd1011474;
            6'd51: f = 21'd1071619;
            default: f = 21'd0;
        endcase
        return f;
    endfunction
endpackage

// File: hw/rtl/piano_key_spectrum_meter.sv
// ----------------------------------------------------------------------------
// piano_key_spectrum_meter
// Peak-hold spectrum meter with decay for the 52 white piano keys.
// ----------------------------------------------------------------------------
// channel   | handshake      | payload
// input     | i_push/o_full  | command, bin_number, bin_real, bin_imag, key_number
// result    | o_empty/i_pop  | key_echo, red, green, blue, lit
// config    | i_cfg_we       | i_cfg_addr, i_cfg_data
// A load is done in the back end as it is taken; a query runs the 27-bit bin
// divider and the 24-step square root. A query that ends black early leaves
// from the divider (bad key, no frame, zero rate) or after the bin read (bad bin).
// Up to four items wait in the input queue. A query whose result is not taken
// holds the back end. Reset is synchronous; the bin store is not cleared.
module piano_key_spectrum_meter import pksm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_command,
    input  logic [11:0] i_bin_number,
    input  logic signed [23:0] i_bin_real,
    input  logic signed [23:0] i_bin_imag,
    input  logic [5:0]  i_key_number,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [5:0]  o_key_echo,
    output logic [7:0]  o_red,
    output logic [7:0]  o_green,
    output logic [7:0]  o_blue,
    output logic        o_lit,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [17:0] i_cfg_data
);
    logic [17:0] r_sample_rate;
    logic [3:0]  r_fft_log2;
    t_item       w_in, w_q;
    t_result     w_res;
    logic        w_qv, w_take, w_rv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= 18'd44100;
            r_fft_log2    <= 4'd10;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == REG_SAMPLE_RATE) r_sample_rate <= i_cfg_data;
            if (i_cfg_addr == REG_FFT_LOG2)    r_fft_log2 <= i_cfg_data[3:0];
        end
    end

    assign w_in = '{cmd: i_command, bin: i_bin_number, re: i_bin_real,
                    im: i_bin_imag, key: i_key_number};

    pksm_front u_front (
        .i_clk, .i_rst_n, .i_push, .o_full, .i_item(w_in),
        .o_valid(w_qv), .o_item(w_q), .i_take(w_take)
    );

    pksm_back u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .i_item(w_q), .o_take(w_take),
        .i_sample_rate(r_sample_rate), .i_fft_log2(r_fft_log2),
        .o_res_valid(w_rv), .o_res(w_res), .i_res_take(i_pop && w_rv)
    );

    assign o_empty    = !w_rv;
    assign o_key_echo = w_res.key;
    assign o_red      = w_res.r;
    assign o_green    = w_res.g;
    assign o_blue     = w_res.b;
    assign o_lit      = w_res.lit;
endmodule

// File: hw/rtl/pksm_front.sv
// ----------------------------------------------------------------------------
// pksm_front
// Input side: takes items and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module pksm_front import pksm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_item i_item,
    output logic  o_valid,
    output t_item o_item,
    input  logic  i_take
);
    t_item      r_q [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       w_push;

    assign o_full  = (r_cnt == 3'd4);
    assign w_push  = i_push && !o_full;
    assign o_valid = (r_cnt != 3'd0);
    assign o_item  = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (i_take) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + 3'(w_push) - 3'(i_take);
        end
    end
endmodule

// File: hw/rtl/pksm_back.sv
// ----------------------------------------------------------------------------
// pksm_back
// Execution side: bin store, key-to-bin divide, square root, peak and color.
// ----------------------------------------------------------------------------
module pksm_back import pksm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_take,
    input  logic [17:0] i_sample_rate,
    input  logic [3:0]  i_fft_log2,
    output logic        o_res_valid,
    output t_result     o_res,
    input  logic        i_res_take
);
    t_state r_state, n_state;
    t_item  r_it;
    logic [47:0] r_store [STORE_DEPTH];
    logic [47:0] r_rd;
    logic [31:0] r_peak [NUM_KEYS];
    logic [NUM_KEYS-1:0] r_pvld;
    logic [31:0] r_pkrd;
    logic [31:0] w_pkold;
    logic        r_frame;
    logic [3:0]  w_lg;
    logic [12:0] w_maxbin;
    // divider: num < 2^35, divisor aligned to the top quotient bit
    logic [37:0] r_num;
    logic [52:0] r_den;
    logic [26:0] r_quo;
    logic [5:0]  r_cnt;
    logic        w_ge;
    // sqrt
    logic [47:0] r_x, r_res, r_bit;
    logic [31:0] r_pk;
    logic [41:0] r_hue;
    logic [2:0]  r_sec;
    logic [13:0] r_rem;
    logic [6:0]  w_nsum;
    logic [4:0]  w_fold;
    logic [3:0]  w_m15;
    logic [2:0]  w_sec;
    logic [7:0]  w_up, w_dn;
    logic [22:0] r_upm, r_dnm;
    logic [23:0] w_are, w_aim;
    logic [47:0] w_re2, w_im2;
    logic [23:0] r_are, r_aim;
    logic [47:0] r_sq1;
    t_result     r_out;
    t_result     r_hold;
    logic        r_ov;

    assign w_lg = (i_fft_log2 > 4'(MAX_FFT_LOG2)) ? 4'(MAX_FFT_LOG2) : i_fft_log2;
    assign w_maxbin = 13'((14'd1 << w_lg) >> 1) + 13'd1;
    assign w_ge = ({15'd0, r_num} >= r_den);
    assign w_are = r_rd[47] ? 24'(-r_rd[47:24]) : r_rd[47:24];
    assign w_aim = r_rd[23] ? 24'(-r_rd[23:0]) : r_rd[23:0];
    assign w_re2 = r_are * r_are;
    assign w_im2 = r_aim * r_aim;
    assign w_pkold = r_pvld[r_it.key] ? r_pkrd : 32'd0;

    assign o_take      = (r_state == ST_IDLE) && i_valid;
    assign o_res_valid = r_ov;
    assign o_res       = r_hold;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_valid && i_item.cmd == CMD_QUERY) n_state = ST_DIV;
            ST_DIV: begin
                if (r_it.key >= 6'(NUM_KEYS) || !r_frame || i_sample_rate == '0)
                    n_state = ST_OUT;
                else if (r_cnt == 6'd26) n_state = ST_READ;
            end
            ST_READ: begin
                if (r_quo == '0 || r_quo > 27'(w_maxbin)) n_state = ST_OUT;
                else n_state = ST_WAIT;
            end
            ST_WAIT:  n_state = ST_MAG;
            ST_MAG:   n_state = ST_SQRT;
            ST_SQRT:  if (r_sq1 == '0 && r_bit == 48'd1) n_state = ST_PEAK;
            ST_PEAK:  n_state = ST_HUE;
            ST_HUE:   n_state = ST_SECT;
            ST_SECT:  n_state = ST_COLOR;
            ST_COLOR: n_state = ST_DECAY;
            ST_DECAY: n_state = ST_OUT;
            ST_OUT:   if (!r_ov || i_res_take) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (r_state == ST_OUT && (!r_ov || i_res_take)) r_ov <= 1'b1;
        else if (i_res_take) r_ov <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && (!r_ov || i_res_take)) r_hold <= r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_frame <= 1'b0;
        else if (o_take && i_item.cmd == CMD_LOAD) r_frame <= 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (o_take && i_item.cmd == CMD_LOAD && 13'(i_item.bin) <= w_maxbin)
            r_store[i_item.bin] <= {i_item.re, i_item.im};
        r_rd <= r_store[r_quo[BIN_W-1:0]];
    end

    // peak memory; a key never written reads as zero through its valid bit
    always_ff @(posedge i_clk) begin
        if (r_state == ST_DECAY)
            r_peak[r_it.key] <= 32'((48'(r_pk) * 48'd58982) >> 16);
        r_pkrd <= r_peak[r_it.key];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_pvld <= '0;
        else if (r_state == ST_DECAY) r_pvld[r_it.key] <= 1'b1;
    end

    // hue mod 15360: 15360 = 15 * 1024, and 16 = 1 mod 15, so sum nibbles
    always_comb begin
        w_nsum = '0;
        for (int i = 0; i < 8; i++) w_nsum = w_nsum + 7'(r_hue[10 + 4*i +: 4]);
        w_fold = 5'(w_nsum[6:4]) + 5'(w_nsum[3:0]);
        w_m15  = (w_fold >= 5'd15) ? 4'(w_fold - 5'd15) : w_fold[3:0];
        w_sec  = (r_hue >= 42'(5 * SECTOR_Q8)) ? 3'd5 :
                 (r_hue >= 42'(4 * SECTOR_Q8)) ? 3'd4 :
                 (r_hue >= 42'(3 * SECTOR_Q8)) ? 3'd3 :
                 (r_hue >= 42'(2 * SECTOR_Q8)) ? 3'd2 :
                 (r_hue >= 42'(SECTOR_Q8))     ? 3'd1 : 3'd0;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_it  <= i_item;
                // bin = (F*2N + sr*256) / (sr*512)
                r_num <= 38'(({17'd0, key_freq(i_item.key)} << (w_lg + 4'd1)))
                       + 38'({i_sample_rate, 8'd0});
                r_den <= {i_sample_rate, 35'd0};
                r_quo <= '0;
                r_cnt <= '0;
                r_out <= '0;
            end
            ST_DIV: begin
                // restoring divide, one quotient bit per cycle (27 bits)
                if (w_ge) begin
                    r_num <= r_num - r_den[37:0];
                    r_quo <= {r_quo[25:0], 1'b1};
                end else begin
                    r_quo <= {r_quo[25:0], 1'b0};
                end
                r_den <= r_den >> 1;
                r_cnt <= r_cnt + 6'd1;
                r_out.key <= r_it.key;
            end
            ST_WAIT: begin
                r_are <= w_are;
                r_aim <= w_aim;
            end
            ST_MAG: begin
                r_sq1 <= w_re2;
                r_x   <= w_im2;
                r_res <= '0;
                r_bit <= 48'd1 << 46;
            end
            ST_SQRT: begin
                if (r_sq1 != '0) begin
                    r_x <= r_x + r_sq1;
                    r_sq1 <= '0;
                end else begin
                    if (r_x >= r_res + r_bit) begin
                        r_x   <= r_x - (r_res + r_bit);
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end
            end
            ST_PEAK: begin
                if ({r_res[39:0], 8'd0} > 48'(w_pkold)) r_pk <= {r_res[23:0], 8'd0};
                else r_pk <= w_pkold;
            end
            ST_HUE: r_hue <= 42'((42'(r_pk) * 42'd720) >> w_lg);
            ST_SECT: begin
                r_sec <= w_sec;
                r_rem <= {w_m15, r_hue[9:0]};
            end
            ST_COLOR: begin
                r_upm <= 23'(r_rem * 14'd0 + 23'(r_rem) * 23'd254);
                r_dnm <= 23'(23'(14'(SECTOR_Q8) - r_rem) * 23'd254);
            end
            ST_DECAY: begin
                r_out.lit <= 1'b1;
                case (r_sec)
                    3'd0: begin r_out.r <= 8'd254; r_out.g <= w_up; r_out.b <= 8'd0; end
                    3'd1: begin r_out.r <= w_dn; r_out.g <= 8'd254; r_out.b <= 8'd0; end
                    3'd2: begin r_out.r <= 8'd0; r_out.g <= 8'd254; r_out.b <= w_up; end
                    3'd3: begin r_out.r <= 8'd0; r_out.g <= w_dn; r_out.b <= 8'd254; end
                    3'd4: begin r_out.r <= w_up; r_out.g <= 8'd0; r_out.b <= 8'd254; end
                    default: begin r_out.r <= 8'd254; r_out.g <= 8'd0; r_out.b <= w_dn; end
                endcase
            end
            default: ;
        endcase
    end

    // scale by 1/15360: x/15360 = (x>>10)/15, and y/15 = (y*4370)>>16 for y < 3811
    always_comb begin
        w_up = 8'((25'(12'(r_upm >> 10)) * 25'd4370) >> 16);
        w_dn = 8'((25'(12'(r_dnm >> 10)) * 25'd4370) >> 16);
    end
endmodule

// File: hw/rtl/pksm_checker.sv
// ----------------------------------------------------------------------------
// pksm_checker
// Port-level checks of the spectrum meter.
// ----------------------------------------------------------------------------
`include "piano_key_spectrum_meter_assert.svh"
module pksm_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_empty,
    input logic       i_pop,
    input logic       o_lit,
    input logic [7:0] o_red,
    input logic [7:0] o_green,
    input logic [7:0] o_blue
);
    `PKSM_ASSERT(a_dark, i_clk, i_rst_n, (!o_empty && !o_lit) |-> (o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd0))
    `PKSM_ASSERT(a_r_max, i_clk, i_rst_n, !o_empty |-> (o_red != 8'd255 && o_green != 8'd255 && o_blue != 8'd255))
    `PKSM_ASSERT(a_hold, i_clk, i_rst_n, (!o_empty && !i_pop) |=> (!o_empty && $stable(o_red)))
    `PKSM_ASSERT_ALWAYS(a_rst, i_clk, !$past(i_rst_n) |-> o_empty)
endmodule

bind piano_key_spectrum_meter pksm_checker u_chk (.*);

// File: tb/tb_piano_key_spectrum_meter.sv
// ----------------------------------------------------------------------------
// tb_piano_key_spectrum_meter
// Self-checking bench for the key spectrum meter. A queue-fed driver offers
// load and query items in random bursts, a monitor pops colors on its own
// stall pattern, and an in-bench peak-hold/color predictor checks each one.
// Runs directed items, then random frames over several rate/length settings.
// ----------------------------------------------------------------------------
module tb_piano_key_spectrum_meter;
    import pksm_pkg::*;

    localparam int  LIMIT_CYCLES = 1000000;
    localparam int  SETTLE       = 60;

    localparam logic [20:0] PITCH_Q8 [52] = '{
        7040, 7902, 8372, 9397, 10548, 11175, 12544,
        14080, 15804, 16744, 18795, 21096, 22351, 25088,
        28160, 31609, 33488, 37589, 42192, 44701, 50175,
        56320, 63217, 66976, 75178, 84385, 89402, 100351,
        112640, 126434, 133952, 150356, 168769, 178805, 200702,
        225280, 252868, 267904, 300713, 337539, 357609, 401403,
        450560, 505736, 535808, 601426, 675077, 715220, 802806,
        901120, 1011474, 1071619
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_push;
    logic        o_full;
    logic        i_command;
    logic [11:0] i_bin_number;
    logic signed [23:0] i_bin_real;
    logic signed [23:0] i_bin_imag;
    logic [5:0]  i_key_number;
    logic        o_empty;
    logic        i_pop;
    logic [5:0]  o_key_echo;
    logic [7:0]  o_red;
    logic [7:0]  o_green;
    logic [7:0]  o_blue;
    logic        o_lit;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_addr;
    logic [17:0] i_cfg_data;

    piano_key_spectrum_meter dut (.*);

    always begin
        i_clk = 1'b1; #2;
        i_clk = 1'b0; #2;
    end

    // predictor state
    logic [23:0] bin_re_q [STORE_DEPTH];
    logic [23:0] bin_im_q [STORE_DEPTH];
    logic [31:0] key_peak [NUM_KEYS];
    bit          have_frame;
    logic [17:0] rate_hz;
    logic [3:0]  len_log2;

    // stimulus-side view, used to keep queries off never-written bins
    bit          gen_written [STORE_DEPTH];
    bit          gen_frame;
    logic [17:0] gen_rate;
    logic [3:0]  gen_log2;

    t_item   pending_items [$];
    t_result color_q [$];
    int      errors;
    int      accepted;
    int      cyc;
    int      gap_left;
    int      burst_left;
    int      hold_left;
    bit      hold_done;

    function automatic int eff_log2(input logic [3:0] lg);
        return (lg > MAX_FFT_LOG2) ? MAX_FFT_LOG2 : int'(lg);
    endfunction

    function automatic longint key_bin(input int key, input logic [17:0] sr,
                                       input logic [3:0] lg);
        longint n;
        n = longint'(1) << eff_log2(lg);
        return (longint'(PITCH_Q8[key]) * n * 2 + longint'(sr) * 256) /
               (longint'(sr) * 512);
    endfunction

    function automatic longint mag24(input logic [23:0] v);
        longint s;
        s = longint'($signed(v));
        return (s < 0) ? -s : s;
    endfunction

    function automatic longint int_sqrt(input longint x);
        longint root;
        longint cand;
        root = 0;
        for (int b = 25; b >= 0; b--) begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= x) root = cand;
        end
        return root;
    endfunction

    function automatic bit meter_predict(input t_item it, output t_result res);
        int     lg;
        longint n, max_bin, bin, re, im, peak, hue, sector, rem, up, down;
        lg = eff_log2(len_log2);
        n = longint'(1) << lg;
        max_bin = n / 2 + 1;
        res = '0;
        if (it.cmd == CMD_LOAD) begin
            have_frame = 1'b1;
            if (it.bin <= max_bin && it.bin < STORE_DEPTH) begin
                bin_re_q[it.bin] = it.re;
                bin_im_q[it.bin] = it.im;
            end
            return 1'b0;
        end
        res.key = it.key;
        if (it.key >= NUM_KEYS || !have_frame || rate_hz == 0) return 1'b1;
        bin = key_bin(it.key, rate_hz, len_log2);
        if (bin == 0 || bin > max_bin || bin >= STORE_DEPTH) return 1'b1;
        re = mag24(bin_re_q[bin]);
        im = mag24(bin_im_q[bin]);
        peak = longint'(key_peak[it.key]);
        if ((int_sqrt(re * re + im * im) << 8) > peak)
            peak = int_sqrt(re * re + im * im) << 8;
        peak = peak & 64'hFFFF_FFFF;
        hue = (peak * 720) >> lg;
        sector = hue / SECTOR_Q8;
        rem = hue % SECTOR_Q8;
        up = rem * 254 / SECTOR_Q8;
        down = (SECTOR_Q8 - rem) * 254 / SECTOR_Q8;
        case (sector)
            0: begin res.r = 254; res.g = up[7:0]; res.b = 0; end
            1: begin res.r = down[7:0]; res.g = 254; res.b = 0; end
            2: begin res.r = 0; res.g = 254; res.b = up[7:0]; end
            3: begin res.r = 0; res.g = down[7:0]; res.b = 254; end
            4: begin res.r = up[7:0]; res.g = 0; res.b = 254; end
            default: begin res.r = 254; res.g = 0; res.b = down[7:0]; end
        endcase
        res.lit = 1'b1;
        key_peak[it.key] = 32'((peak * 58982) >> 16);
        return 1'b1;
    endfunction

    task automatic report(input string what, input int want, input int got);
        errors++;
        $display("mismatch %s: expected %0d got %0d (cycle %0d)", what, want, got, cyc);
    endtask

    // ---------------- stimulus building ----------------
    function automatic logic [23:0] rand_part();
        logic [23:0] x;
        x = $urandom;
        return 24'($signed(x) >>> $urandom_range(0, 23));
    endfunction

    task automatic add_load(input int bin, input logic [23:0] re, input logic [23:0] im);
        t_item it;
        it = '0;
        it.cmd = CMD_LOAD;
        it.bin = bin[11:0];
        it.re = re;
        it.im = im;
        it.key = 6'($urandom);
        gen_frame = 1'b1;
        if (bin <= (1 << eff_log2(gen_log2)) / 2 + 1 && bin < STORE_DEPTH)
            gen_written[bin] = 1'b1;
        pending_items.push_back(it);
    endtask

    task automatic add_query(input int key);
        t_item  it;
        longint bin;
        if (key < NUM_KEYS && gen_frame && gen_rate != 0) begin
            bin = key_bin(key, gen_rate, gen_log2);
            if (bin != 0 && bin <= (1 << eff_log2(gen_log2)) / 2 + 1 &&
                bin < STORE_DEPTH && !gen_written[bin])
                add_load(int'(bin), rand_part(), rand_part());
        end
        it = '0;
        it.cmd = CMD_QUERY;
        it.bin = 12'($urandom);
        it.re = 24'($urandom);
        it.im = 24'($urandom);
        it.key = key[5:0];
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || color_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [17:0] sr, input logic [3:0] lg);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_SAMPLE_RATE;
        i_cfg_data <= sr;
        @(posedge i_clk);
        i_cfg_addr <= REG_FFT_LOG2;
        i_cfg_data <= 18'(lg);
        rate_hz = sr;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        len_log2 = lg;
        gen_rate = sr;
        gen_log2 = lg;
    endtask

    task automatic random_items(input int count);
        int max_bin;
        max_bin = (1 << eff_log2(gen_log2)) / 2 + 1;
        repeat (count) begin
            if ($urandom_range(0, 99) < 35) begin
                if ($urandom_range(0, 3) != 0)
                    add_load($urandom_range(0, max_bin + 1), rand_part(), rand_part());
                else
                    add_load($urandom_range(0, 4095), rand_part(), rand_part());
            end else begin
                if ($urandom_range(0, 9) != 0) add_query($urandom_range(0, NUM_KEYS - 1));
                else add_query($urandom_range(NUM_KEYS, 63));
            end
        end
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_push <= 1'b0;
        end else begin
            if (i_push && !o_full) begin
                t_result res;
                if (meter_predict(pending_items.pop_front(), res)) color_q.push_back(res);
                accepted++;
            end
            if (gap_left > 0) begin
                gap_left--;
                i_push <= 1'b0;
            end else if (pending_items.size() != 0) begin
                i_push <= 1'b1;
                i_command <= pending_items[0].cmd;
                i_bin_number <= pending_items[0].bin;
                i_bin_real <= pending_items[0].re;
                i_bin_imag <= pending_items[0].im;
                i_key_number <= pending_items[0].key;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                i_push <= 1'b0;
            end
        end
    end

    // one long receiver hold-off so the input side backs up
    always @(posedge i_clk) begin
        if (hold_left > 0) hold_left <= hold_left - 1;
        else if (!hold_done && accepted >= 600) begin
            hold_left <= 500;
            hold_done <= 1'b1;
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_pop <= 1'b0;
        end else begin
            if (i_pop && !o_empty) begin
                if (color_q.size() == 0) begin
                    report("unexpected color, key", -1, o_key_echo);
                end else begin
                    t_result want;
                    want = color_q.pop_front();
                    if (o_key_echo !== want.key) report("key_echo", want.key, o_key_echo);
                    if (o_red !== want.r) report("red", want.r, o_red);
                    if (o_green !== want.g) report("green", want.g, o_green);
                    if (o_blue !== want.b) report("blue", want.b, o_blue);
                    if (o_lit !== want.lit) report("lit", want.lit, o_lit);
                end
            end
            // stall mode follows cyc[7:6]: free-running, loose, tight, mostly popping
            if (hold_left > 0) i_pop <= 1'b0;
            else case (cyc[7:6])
                2'd0: i_pop <= 1'b1;
                2'd1: i_pop <= $urandom_range(0, 1);
                2'd2: i_pop <= ($urandom_range(0, 4) == 0);
                default: i_pop <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_push = 1'b0;
        i_pop = 1'b0;
        i_command = CMD_LOAD;
        i_bin_number = '0;
        i_bin_real = '0;
        i_bin_imag = '0;
        i_key_number = '0;
        i_cfg_we = 1'b0;
        i_cfg_addr = REG_SAMPLE_RATE;
        i_cfg_data = '0;
        errors = 0;
        accepted = 0;
        cyc = 0;
        gap_left = 0;
        burst_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        foreach (key_peak[k]) key_peak[k] = '0;
        foreach (bin_re_q[b]) begin
            bin_re_q[b] = '0;
            bin_im_q[b] = '0;
            gen_written[b] = 1'b0;
        end
        have_frame = 1'b0;
        gen_frame = 1'b0;
        rate_hz = 18'd44100;
        len_log2 = 4'd10;
        gen_rate = 18'd44100;
        gen_log2 = 4'd10;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed, reset settings (N = 1024, top bin 513)
        add_query(0);                                  // no frame yet
        add_load(2049, 24'h7FFFFF, 24'h7FFFFF);        // out of range, sets frame
        add_load(0, 24'h7FFFFF, 24'h800000);
        add_load(1, 24'h800000, 24'h800000);           // largest magnitude
        add_query(0);
        add_query(0);                                  // decayed peak
        add_query(NUM_KEYS);
        add_query(63);
        add_load(4095, 24'h000001, 24'hFFFFFF);
        add_load(514, 24'h123456, 24'h654321);
        add_load(513, 24'h7FFFFF, 24'h000000);
        add_load(2, 24'h000000, 24'h000000);
        add_query(51);
        add_query(26);
        add_query(13);
        add_load(3, 24'hFFFFFF, 24'h000001);
        add_query(1);
        add_query(2);
        add_query(40);
        drain();

        set_config(18'd1000, 4'd1);
        random_items(130);
        drain();
        set_config(18'd262143, 4'd12);
        random_items(180);
        drain();
        set_config(18'd0, 4'd10);
        random_items(60);
        drain();
        set_config(18'd192000, 4'd15);
        random_items(220);
        drain();
        set_config(18'd48000, 4'd0);
        random_items(90);
        drain();
        set_config(18'd8000, 4'd6);
        random_items(220);
        drain();
        set_config(18'd44100, 4'd11);
        random_items(250);
        drain();
        set_config(18'd22050, 4'd9);
        random_items(220);
        drain();

        if (errors == 0) $display("Regression PASS");
        else $display("Regression FAIL");
        $finish;
    end
endmodule
